// ===== rtl/otmp_pkg.sv =====
// Shared types, constants and IEEE conversion functions of the tuning message parser.
`timescale 1ns / 1ps
`default_nettype none
package otmp_pkg;

    localparam int MAX_PACKET_BYTES = 2048;
    localparam int TUNING_ARGS      = 8;
    localparam int OFS_W            = $clog2(MAX_PACKET_BYTES + 1);
    localparam int ARG_IDX_W        = $clog2(TUNING_ARGS);

    // Result kinds reported at the end of a packet.
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_HB   = 2'd1;
    localparam logic [1:0] KIND_TUNE = 2'd2;

    // Argument type codes kept in the tag store.
    localparam logic [1:0] TG_I   = 2'd0;
    localparam logic [1:0] TG_F   = 2'd1;
    localparam logic [1:0] TG_D   = 2'd2;
    localparam logic [1:0] TG_BAD = 2'd3;

    localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

    // Heartbeat and tuning address strings, one byte per entry.
    localparam int HB_LEN = 20;
    localparam int TU_LEN = 24;
    localparam logic [7:0] HB_NAME [HB_LEN] = '{
        8'h2F, 8'h70, 8'h69, 8'h74, 8'h63, 8'h68, 8'h67, 8'h72, 8'h69, 8'h64,
        8'h2F, 8'h68, 8'h65, 8'h61, 8'h72, 8'h74, 8'h62, 8'h65, 8'h61, 8'h74};
    localparam logic [7:0] TU_NAME [TU_LEN] = '{
        8'h2F, 8'h70, 8'h69, 8'h74, 8'h63, 8'h68, 8'h67, 8'h72, 8'h69, 8'h64,
        8'h2F, 8'h70, 8'h6C, 8'h75, 8'h67, 8'h69, 8'h6E, 8'h2F, 8'h74, 8'h75,
        8'h6E, 8'h69, 8'h6E, 8'h67};

    // One queue entry: what the back end must do for one item.
    typedef struct packed {
        logic       tick;
        logic [1:0] kind;
        logic       upd;
    } otmp_cmd_t;

    // Position of the highest set bit.
    function automatic logic [4:0] top_bit(input logic [31:0] v);
        logic [4:0] h;
        h = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) h = 5'(i);
        end
        return h;
    endfunction

    function automatic logic [63:0] i32_to_f64(input logic [31:0] v);
        logic        s;
        logic [31:0] mag;
        logic [4:0]  h;
        logic [63:0] sh;
        s   = v[31];
        mag = s ? (32'd0 - v) : v;
        h   = top_bit(mag);
        sh  = {32'd0, mag} << (6'd52 - {1'b0, h});
        if (mag == 32'd0) return 64'd0;
        return {s, 11'(h) + 11'd1023, sh[51:0]};
    endfunction

    function automatic logic [63:0] f32_to_f64(input logic [31:0] b);
        logic        s;
        logic [7:0]  e;
        logic [22:0] m;
        logic [4:0]  h;
        logic [63:0] sh;
        logic [63:0] res;
        s  = b[31];
        e  = b[30:23];
        m  = b[22:0];
        h  = top_bit({9'd0, m});
        sh = {41'd0, m} << (6'd52 - {1'b0, h});
        if (e == 8'hFF) begin
            res = {s, 11'h7FF, (m != 23'd0) ? ({m, 29'd0} | (52'd1 << 51)) : 52'd0};
        end
        else if (e == 8'd0) begin
            if (m == 23'd0) res = {s, 63'd0};
            else            res = {s, 11'(h) + 11'd874, sh[51:0]};
        end
        else begin
            res = {s, 11'(e) + 11'd896, m, 29'd0};
        end
        return res;
    endfunction

    // Truncate toward zero with saturation; NaN gives zero.
    function automatic logic [31:0] f64_to_i32(input logic [63:0] b);
        logic        s;
        logic [10:0] ex;
        logic [51:0] man;
        logic [10:0] e;
        logic [52:0] mag;
        logic [31:0] res;
        s   = b[63];
        ex  = b[62:52];
        man = b[51:0];
        e   = ex - 11'd1023;
        mag = {1'b1, man} >> (6'd52 - e[5:0]);
        if (ex == 11'h7FF && man != 52'd0) res = 32'd0;
        else if (ex < 11'd1023)            res = 32'd0;
        else if (e >= 11'd31)              res = s ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else                               res = s ? (32'd0 - mag[31:0]) : mag[31:0];
        return res;
    endfunction

    function automatic logic [30:0] count_of(input logic [63:0] b);
        logic [31:0] v;
        v = f64_to_i32(b);
        if (v == 32'd0 || v[31]) return 31'd1;
        return v[30:0];
    endfunction

    // Round to single, nearest-even.
    function automatic logic [31:0] f64_to_f32(input logic [63:0] b);
        logic        s;
        logic [10:0] ex;
        logic [51:0] man;
        logic [63:0] m;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] half;
        logic [31:0] res;
        int          e;
        int          sh;
        s   = b[63];
        ex  = b[62:52];
        man = b[51:0];
        m   = {11'd0, 1'b1, man};
        e   = int'(ex) - 1023;
        sh  = (e >= -126) ? 29 : 29 + (-126 - e);
        res = 32'd0;
        q   = 64'd0;
        r   = 64'd0;
        half = 64'd0;
        if (ex == 11'h7FF) begin
            res = (man != 52'd0) ? (32'h7FC0_0000 | {9'd0, man[51:29]}) : 32'h7F80_0000;
        end
        else if (ex != 11'd0 && sh <= 60) begin
            q    = m >> sh;
            r    = m & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            if (r > half || (r == half && q[0])) q = q + 64'd1;
            if (e >= -126) begin
                if (e + 127 >= 255) begin
                    res = 32'h7F80_0000;
                end
                else begin
                    res = (32'(e + 126) << 23) + q[31:0];
                    if (res >= 32'h7F80_0000) res = 32'h7F80_0000;
                end
            end
            else begin
                res = q[31:0];
            end
        end
        return {s, res[30:0]};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/otmp_if.sv =====
// Handshake interfaces for the request and response channels.
`timescale 1ns / 1ps
`default_nettype none
interface otmp_req_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source(output valid, func, data_byte, last_byte, input ready);
    modport sink(input valid, func, data_byte, last_byte, output ready);
endinterface

interface otmp_rsp_if;
    logic        valid;
    logic        ready;
    logic        connected;
    logic [1:0]  msg_kind;
    logic        tuning_updated;
    logic [31:0] mode;
    logic [63:0] root_bits;
    logic [63:0] stretch;
    logic [63:0] skew;
    logic [31:0] offset_bits;
    logic [30:0] steps;
    logic [30:0] mos_a;
    logic [30:0] mos_b;
    modport source(output valid, connected, msg_kind, tuning_updated, mode, root_bits,
                   stretch, skew, offset_bits, steps, mos_a, mos_b, input ready);
    modport sink(input valid, connected, msg_kind, tuning_updated, mode, root_bits,
                 stretch, skew, offset_bits, steps, mos_a, mos_b, output ready);
endinterface
`default_nettype wire

// ===== rtl/osc_tuning_message_parser.sv =====
// Top level of the tuning message parser.
// Usage:
// The req channel carries one item per handshake: a datagram byte (func 0, with
// last_byte on the final byte) or a one-millisecond tick (func 1).
// Every accepted item yields exactly one response item on rsp, in order.
// The rsp item shows the link status, the message kind at a packet's last byte,
// whether the tuning was replaced, and the stored tuning fields.
// An accepted item passes through the queue and then the response register before
// it shows on rsp. The req channel takes one item per cycle while the queue is not
// full, set by the parse step in the front end and the commit in the back end.
// A two-entry queue separates the two; when rsp.ready stays low the response
// register holds, the queue fills and req.ready falls after at most two more items.
// The timeout register is written through cfg_we / cfg_wdata, by the user only
// while idle; the block itself does not enforce it.
// Reset clears the parser, the timer and the link status, loads a timeout
// of 2000 and sets the three counts of the tuning to one.
`timescale 1ns / 1ps
`default_nettype none
module osc_tuning_message_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    otmp_req_if.sink         req,
    otmp_rsp_if.source       rsp,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata
);

    otmp_pkg::otmp_cmd_t cmd;
    otmp_pkg::otmp_cmd_t head;
    logic                push;
    logic                full;
    logic                pop;
    logic                not_empty;
    logic [63:0]         pending [otmp_pkg::TUNING_ARGS];

    otmp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .q_full   (full),
        .cmd      (cmd),
        .cmd_push (push),
        .pending  (pending)
    );

    otmp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (cmd),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    otmp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .q_not_empty (not_empty),
        .q_head      (head),
        .q_pop       (pop),
        .pending     (pending),
        .rsp         (rsp)
    );

endmodule
`default_nettype wire

// ===== rtl/otmp_front.sv =====
// Front end: accepts items, parses packet bytes and queues one command per item.
`timescale 1ns / 1ps
`default_nettype none
module otmp_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    otmp_req_if.sink                    req,
    input  wire logic                   q_full,
    output otmp_pkg::otmp_cmd_t         cmd,
    output logic                        cmd_push,
    output logic [63:0]                 pending [otmp_pkg::TUNING_ARGS]
);

    typedef enum logic [7:0] {
        PH_ADDR = 8'b0000_0001,
        PH_APAD = 8'b0000_0010,
        PH_TAG0 = 8'b0000_0100,
        PH_TAGS = 8'b0000_1000,
        PH_TPAD = 8'b0001_0000,
        PH_ARGS = 8'b0010_0000,
        PH_DONE = 8'b0100_0000,
        PH_DROP = 8'b1000_0000
    } phase_t;

    phase_t                          phase_reg, phase_next;
    logic [otmp_pkg::OFS_W-1:0]      ofs_reg, ofs_next;
    logic [1:0]                      am_reg, am_next;
    logic [1:0]                      tags_reg [otmp_pkg::TUNING_ARGS];
    logic [1:0]                      tags_next [otmp_pkg::TUNING_ARGS];
    logic [3:0]                      tc_reg, tc_next;
    logic [63:0]                     asm_reg, asm_next;
    logic [3:0]                      ab_reg, ab_next;
    logic [3:0]                      ac_reg, ac_next;
    logic                            pend_we;
    logic [otmp_pkg::ARG_IDX_W-1:0]  pend_idx;
    logic [63:0]                     pend_data;
    logic                            accept;

    // True when argument parsing should stop before argument ac.
    function automatic logic args_done(input logic [3:0] ac, input logic [3:0] tc,
                                       input logic [1:0] tg [otmp_pkg::TUNING_ARGS]);
        if (ac >= 4'(otmp_pkg::TUNING_ARGS) || ac >= tc) return 1'b1;
        return tg[ac[otmp_pkg::ARG_IDX_W-1:0]] == otmp_pkg::TG_BAD;
    endfunction

    assign req.ready = !q_full;
    assign accept    = req.valid && req.ready;
    assign cmd_push  = accept;

    // Parse step for one accepted item.
    always_comb
    begin
        logic [otmp_pkg::OFS_W-1:0] pos;
        logic                       aligned;
        logic [7:0]                 b;
        logic [1:0]                 code;
        logic [3:0]                 need;
        pos        = ofs_reg;
        b          = req.data_byte;
        aligned    = (pos[1:0] == 2'b11);
        code       = otmp_pkg::TG_BAD;
        need       = 4'd4;
        phase_next = phase_reg;
        ofs_next   = ofs_reg;
        am_next    = am_reg;
        tags_next  = tags_reg;
        tc_next    = tc_reg;
        asm_next   = asm_reg;
        ab_next    = ab_reg;
        ac_next    = ac_reg;
        pend_we    = 1'b0;
        pend_idx   = ac_reg[otmp_pkg::ARG_IDX_W-1:0];
        pend_data  = 64'd0;
        cmd.tick   = req.func;
        cmd.kind   = otmp_pkg::KIND_NONE;
        cmd.upd    = 1'b0;
        if (accept && !req.func) begin
            if (ofs_reg < otmp_pkg::OFS_W'(otmp_pkg::MAX_PACKET_BYTES)) begin
                ofs_next = ofs_reg + 1'b1;
                case (phase_reg)
                    PH_ADDR:
                    begin
                        if (b == 8'd0) begin
                            am_next = am_reg & {pos == otmp_pkg::OFS_W'(otmp_pkg::TU_LEN),
                                                pos == otmp_pkg::OFS_W'(otmp_pkg::HB_LEN)};
                            if (am_next == 2'b00) phase_next = PH_DROP;
                            else                  phase_next = aligned ? PH_TAG0 : PH_APAD;
                        end
                        else begin
                            if (!(pos < otmp_pkg::OFS_W'(otmp_pkg::HB_LEN) &&
                                  otmp_pkg::HB_NAME[pos[4:0]] == b)) am_next[0] = 1'b0;
                            if (!(pos < otmp_pkg::OFS_W'(otmp_pkg::TU_LEN) &&
                                  otmp_pkg::TU_NAME[pos[4:0]] == b)) am_next[1] = 1'b0;
                            if (am_next == 2'b00) phase_next = PH_DROP;
                        end
                    end
                    PH_APAD:
                    begin
                        if (aligned) phase_next = PH_TAG0;
                    end
                    PH_TAG0:
                    begin
                        phase_next = (b == 8'h2C) ? PH_TAGS : PH_DROP;
                    end
                    PH_TAGS:
                    begin
                        if (b == 8'd0) begin
                            if (am_reg[0]) begin
                                phase_next = PH_DONE;
                            end
                            else if (aligned) begin
                                phase_next = args_done(ac_reg, tc_reg, tags_reg) ?
                                             PH_DONE : PH_ARGS;
                            end
                            else begin
                                phase_next = PH_TPAD;
                            end
                        end
                        else if (tc_reg < 4'(otmp_pkg::TUNING_ARGS)) begin
                            if (b == 8'h69)      code = otmp_pkg::TG_I;
                            else if (b == 8'h66) code = otmp_pkg::TG_F;
                            else if (b == 8'h64) code = otmp_pkg::TG_D;
                            tags_next[tc_reg[otmp_pkg::ARG_IDX_W-1:0]] = code;
                            tc_next = tc_reg + 1'b1;
                        end
                    end
                    PH_TPAD:
                    begin
                        if (aligned) begin
                            phase_next = args_done(ac_reg, tc_reg, tags_reg) ?
                                         PH_DONE : PH_ARGS;
                        end
                    end
                    PH_ARGS:
                    begin
                        if (ac_reg >= 4'(otmp_pkg::TUNING_ARGS)) begin
                            phase_next = PH_DONE;
                        end
                        else begin
                            code     = tags_reg[ac_reg[otmp_pkg::ARG_IDX_W-1:0]];
                            asm_next = {asm_reg[55:0], b};
                            ab_next  = ab_reg + 1'b1;
                            need     = (code == otmp_pkg::TG_D) ? 4'd8 : 4'd4;
                            if (ab_next >= need) begin
                                pend_we = 1'b1;
                                if (code == otmp_pkg::TG_I)
                                    pend_data = otmp_pkg::i32_to_f64(asm_next[31:0]);
                                else if (code == otmp_pkg::TG_F)
                                    pend_data = otmp_pkg::f32_to_f64(asm_next[31:0]);
                                else
                                    pend_data = asm_next;
                                ac_next  = ac_reg + 1'b1;
                                asm_next = 64'd0;
                                ab_next  = 4'd0;
                                if (args_done(ac_next, tc_reg, tags_reg)) phase_next = PH_DONE;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            // End of packet: report and start over.
            if (req.last_byte) begin
                if (phase_next == PH_TAGS || phase_next == PH_TPAD ||
                    phase_next == PH_ARGS || phase_next == PH_DONE) begin
                    cmd.kind = am_next[0] ? otmp_pkg::KIND_HB : otmp_pkg::KIND_TUNE;
                    cmd.upd  = !am_next[0] && ac_next >= 4'(otmp_pkg::TUNING_ARGS);
                end
                phase_next = PH_ADDR;
                ofs_next   = '0;
                am_next    = 2'b11;
                tc_next    = 4'd0;
                asm_next   = 64'd0;
                ab_next    = 4'd0;
                ac_next    = 4'd0;
            end
        end
    end

    // Parse state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_ADDR;
            ofs_reg   <= '0;
            am_reg    <= 2'b11;
            tc_reg    <= 4'd0;
            asm_reg   <= 64'd0;
            ab_reg    <= 4'd0;
            ac_reg    <= 4'd0;
        end
        else begin
            phase_reg <= phase_next;
            ofs_reg   <= ofs_next;
            am_reg    <= am_next;
            tc_reg    <= tc_next;
            asm_reg   <= asm_next;
            ab_reg    <= ab_next;
            ac_reg    <= ac_next;
        end
    end

    // Tag store and finished arguments hold payload only.
    always_ff @(posedge clk)
    begin
        tags_reg <= tags_next;
        if (pend_we) pending[pend_idx] <= pend_data;
    end

endmodule
`default_nettype wire

// ===== rtl/otmp_queue.sv =====
// Two-entry command queue between the parser and the back end.
`timescale 1ns / 1ps
`default_nettype none
module otmp_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  otmp_pkg::otmp_cmd_t       push_cmd,
    output logic                      full,
    input  wire logic                 pop,
    output logic                      not_empty,
    output otmp_pkg::otmp_cmd_t       head
);

    otmp_pkg::otmp_cmd_t slot_reg [2];
    logic                wp_reg, wp_next;
    logic                rp_reg, rp_next;
    logic [1:0]          cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = slot_reg[rp_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) slot_reg[wp_reg] <= push_cmd;
    end

endmodule
`default_nettype wire

// ===== rtl/otmp_back.sv =====
// Back end: connection timer, tuning store and the registered response item.
`timescale 1ns / 1ps
`default_nettype none
module otmp_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [15:0]          cfg_wdata,
    input  wire logic                 q_not_empty,
    input  otmp_pkg::otmp_cmd_t       q_head,
    output logic                      q_pop,
    input  wire logic [63:0]          pending [otmp_pkg::TUNING_ARGS],
    otmp_rsp_if.source                rsp
);

    logic [15:0] timeout_reg;
    logic [31:0] elapsed_reg, elapsed_next;
    logic        seen_reg, seen_next;
    logic        valid_reg, valid_next;
    logic        conn_reg, conn_next;
    logic [1:0]  kind_reg;
    logic        upd_reg;
    logic [31:0] mode_reg;
    logic [63:0] root_reg, stretch_reg, skew_reg;
    logic [31:0] offs_reg;
    logic [30:0] steps_reg, mos_a_reg, mos_b_reg;

    assign q_pop = q_not_empty && (!valid_reg || rsp.ready);

    // Timer and response valid.
    always_comb
    begin
        elapsed_next = elapsed_reg;
        seen_next    = seen_reg;
        if (q_pop) begin
            if (q_head.tick) begin
                if (elapsed_reg != 32'hFFFF_FFFF) elapsed_next = elapsed_reg + 32'd1;
            end
            else if (q_head.kind != otmp_pkg::KIND_NONE) begin
                elapsed_next = 32'd0;
                seen_next    = 1'b1;
            end
        end
        conn_next  = seen_next && (elapsed_next < {16'd0, timeout_reg});
        valid_next = q_pop ? 1'b1 : (valid_reg && !rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            timeout_reg <= otmp_pkg::TIMEOUT_RESET;
            elapsed_reg <= 32'd0;
            seen_reg    <= 1'b0;
            valid_reg   <= 1'b0;
            conn_reg    <= 1'b0;
            kind_reg    <= otmp_pkg::KIND_NONE;
            upd_reg     <= 1'b0;
            mode_reg    <= 32'd0;
            root_reg    <= 64'd0;
            stretch_reg <= 64'd0;
            skew_reg    <= 64'd0;
            offs_reg    <= 32'd0;
            steps_reg   <= 31'd1;
            mos_a_reg   <= 31'd1;
            mos_b_reg   <= 31'd1;
        end
        else begin
            if (cfg_we) timeout_reg <= cfg_wdata;
            elapsed_reg <= elapsed_next;
            seen_reg    <= seen_next;
            valid_reg   <= valid_next;
            if (q_pop) begin
                conn_reg <= conn_next;
                kind_reg <= q_head.tick ? otmp_pkg::KIND_NONE : q_head.kind;
                upd_reg  <= !q_head.tick && q_head.upd;
                // A complete tuning message replaces the stored tuning.
                if (!q_head.tick && q_head.upd) begin
                    mode_reg    <= otmp_pkg::f64_to_i32(pending[0]);
                    root_reg    <= pending[1];
                    stretch_reg <= pending[2];
                    skew_reg    <= pending[3];
                    offs_reg    <= otmp_pkg::f64_to_f32(pending[4]);
                    steps_reg   <= otmp_pkg::count_of(pending[5]);
                    mos_a_reg   <= otmp_pkg::count_of(pending[6]);
                    mos_b_reg   <= otmp_pkg::count_of(pending[7]);
                end
            end
        end
    end

    assign rsp.valid          = valid_reg;
    assign rsp.connected      = conn_reg;
    assign rsp.msg_kind       = kind_reg;
    assign rsp.tuning_updated = upd_reg;
    assign rsp.mode           = mode_reg;
    assign rsp.root_bits      = root_reg;
    assign rsp.stretch        = stretch_reg;
    assign rsp.skew           = skew_reg;
    assign rsp.offset_bits    = offs_reg;
    assign rsp.steps          = steps_reg;
    assign rsp.mos_a          = mos_a_reg;
    assign rsp.mos_b          = mos_b_reg;

endmodule
`default_nettype wire

// ===== rtl/otmp_checker.sv =====
// Port-level checks of the tuning message parser and their binding.
`timescale 1ns / 1ps
`default_nettype none
module otmp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [1:0]  msg_kind,
    input wire logic        tuning_updated,
    input wire logic [30:0] steps,
    input wire logic [30:0] mos_a
);

    // An update is only ever reported with a tuning message.
    a_upd_kind: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && tuning_updated |-> msg_kind == otmp_pkg::KIND_TUNE)
        else $error("tuning update without tuning message");

    // Kind code three is never produced.
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> msg_kind != 2'd3)
        else $error("invalid message kind");

    // The steps and mos_a counts stay at least one.
    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> steps != 31'd0 && mos_a != 31'd0)
        else $error("count below one");

    // A stalled response item stays presented.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(msg_kind))
        else $error("response dropped under stall");

endmodule

bind osc_tuning_message_parser otmp_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .msg_kind       (rsp.msg_kind),
    .tuning_updated (rsp.tuning_updated),
    .steps          (rsp.steps),
    .mos_a          (rsp.mos_a)
);
`default_nettype wire

// ===== verif/otmp_checker.sv =====
// Monitor of the tuning message parser: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module otmp_monitor (
    input  logic        clk,
    input  logic        rst_n,
    otmp_req_if         req,
    otmp_rsp_if         rsp,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    output int          errors,
    output int          pending
);

    // Parse phases of the packet walker.
    localparam int P_ADDR = 0;
    localparam int P_APAD = 1;
    localparam int P_TAG0 = 2;
    localparam int P_TAGS = 3;
    localparam int P_TPAD = 4;
    localparam int P_ARGS = 5;
    localparam int P_DONE = 6;
    localparam int P_DROP = 7;

    typedef struct packed {
        logic        connected;
        logic [1:0]  msg_kind;
        logic        tuning_updated;
        logic [31:0] mode;
        logic [63:0] root_bits;
        logic [63:0] stretch;
        logic [63:0] skew;
        logic [31:0] offset_bits;
        logic [30:0] steps;
        logic [30:0] mos_a;
        logic [30:0] mos_b;
    } status_t;

    status_t     status_q[$];
    int          phase;
    int          offset;
    logic [1:0]  addr_hit;
    logic [1:0]  tags [otmp_pkg::TUNING_ARGS];
    int          tag_cnt;
    logic [63:0] assembly;
    int          asm_bytes;
    int          arg_cnt;
    logic [63:0] args [otmp_pkg::TUNING_ARGS];
    logic [31:0] t_mode;
    logic [63:0] t_root;
    logic [63:0] t_stretch;
    logic [63:0] t_skew;
    logic [31:0] t_offset;
    logic [30:0] t_steps;
    logic [30:0] t_mos_a;
    logic [30:0] t_mos_b;
    logic [31:0] elapsed;
    logic        seen;
    logic [15:0] timeout;

    function automatic int msb_of(input logic [63:0] v);
        int h;
        h = 0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i]) h = i;
        end
        return h;
    endfunction

    function automatic logic [63:0] int_to_double(input logic [31:0] v);
        logic [31:0] mag;
        logic [63:0] frac;
        int          h;
        mag = v[31] ? -v : v;
        if (mag == 0) return 64'd0;
        h = msb_of({32'd0, mag});
        frac = {32'd0, mag} << (52 - h);
        return {v[31], 11'(h + 1023), frac[51:0]};
    endfunction

    function automatic logic [63:0] single_to_double(input logic [31:0] b);
        logic [7:0]  e;
        logic [22:0] m;
        logic [63:0] frac;
        int          h;
        e = b[30:23];
        m = b[22:0];
        if (e == 8'hFF)
            return {b[31], 11'h7FF, (m != 0) ? ({m, 29'd0} | (52'd1 << 51)) : 52'd0};
        if (e == 8'd0)
        begin
            if (m == 0) return {b[31], 63'd0};
            h = msb_of({41'd0, m});
            frac = {41'd0, m} << (52 - h);
            return {b[31], 11'(h + 874), frac[51:0]};
        end
        return {b[31], 11'(e) + 11'd896, m, 29'd0};
    endfunction

    function automatic logic [31:0] double_to_int(input logic [63:0] b);
        int          ex;
        logic [63:0] mag;
        ex = int'(b[62:52]);
        if (ex == 2047 && b[51:0] != 0) return 32'd0;
        if (ex < 1023) return 32'd0;
        if (ex - 1023 >= 31) return b[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        mag = {11'd0, 1'b1, b[51:0]} >> (52 - (ex - 1023));
        return b[63] ? -mag[31:0] : mag[31:0];
    endfunction

    function automatic logic [30:0] double_to_count(input logic [63:0] b);
        logic [31:0] v;
        v = double_to_int(b);
        if (v == 0 || v[31]) return 31'd1;
        return v[30:0];
    endfunction

    // Round to single precision, ties to even.
    function automatic logic [31:0] double_to_single(input logic [63:0] b);
        logic [31:0] s;
        logic [63:0] m;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] half;
        logic [31:0] res;
        int          ex;
        int          e;
        int          shift;
        s = {b[63], 31'd0};
        ex = int'(b[62:52]);
        if (ex == 2047)
            return (b[51:0] != 0) ? (s | 32'h7FC0_0000 | 32'(b[51:29])) : (s | 32'h7F80_0000);
        if (ex == 0) return s;
        e = ex - 1023;
        m = {11'd0, 1'b1, b[51:0]};
        shift = (e >= -126) ? 29 : 29 + (-126 - e);
        if (shift > 60) return s;
        q = m >> shift;
        r = m & ((64'd1 << shift) - 64'd1);
        half = 64'd1 << (shift - 1);
        if (r > half || (r == half && q[0])) q = q + 64'd1;
        if (e >= -126)
        begin
            if (e + 127 >= 255) return s | 32'h7F80_0000;
            res = (32'(e + 126) << 23) + q[31:0];
            if (res >= 32'h7F80_0000) res = 32'h7F80_0000;
        end
        else
        begin
            res = q[31:0];
        end
        return s | res;
    endfunction

    // Argument parsing stops when the tags run out, the limit is hit or a tag is unknown.
    task automatic check_args_left();
        if (arg_cnt >= otmp_pkg::TUNING_ARGS || arg_cnt >= tag_cnt)
            phase = P_DONE;
        else if (tags[arg_cnt] == otmp_pkg::TG_BAD)
            phase = P_DONE;
    endtask

    task automatic clear_packet();
        phase = P_ADDR;
        offset = 0;
        addr_hit = 2'b11;
        tag_cnt = 0;
        assembly = 0;
        asm_bytes = 0;
        arg_cnt = 0;
    endtask

    // Advance the packet walker by one byte at position pos.
    task automatic walk_byte(input logic [7:0] b, input int pos);
        logic       aligned;
        logic [1:0] code;
        int         need;
        aligned = ((pos + 1) % 4) == 0;
        case (phase)
            P_ADDR:
            begin
                if (b == 0)
                begin
                    addr_hit &= {pos == otmp_pkg::TU_LEN, pos == otmp_pkg::HB_LEN};
                    if (addr_hit == 0) phase = P_DROP;
                    else phase = aligned ? P_TAG0 : P_APAD;
                end
                else
                begin
                    if (!(pos < otmp_pkg::HB_LEN && otmp_pkg::HB_NAME[pos] == b))
                        addr_hit[0] = 1'b0;
                    if (!(pos < otmp_pkg::TU_LEN && otmp_pkg::TU_NAME[pos] == b))
                        addr_hit[1] = 1'b0;
                    if (addr_hit == 0) phase = P_DROP;
                end
            end
            P_APAD:
            begin
                if (aligned) phase = P_TAG0;
            end
            P_TAG0:
            begin
                phase = (b == ",") ? P_TAGS : P_DROP;
            end
            P_TAGS:
            begin
                if (b == 0)
                begin
                    if (addr_hit[0]) phase = P_DONE;
                    else if (aligned)
                    begin
                        phase = P_ARGS;
                        check_args_left();
                    end
                    else phase = P_TPAD;
                end
                else if (tag_cnt < otmp_pkg::TUNING_ARGS)
                begin
                    tags[tag_cnt] = (b == "i") ? otmp_pkg::TG_I :
                                    (b == "f") ? otmp_pkg::TG_F :
                                    (b == "d") ? otmp_pkg::TG_D : otmp_pkg::TG_BAD;
                    tag_cnt++;
                end
            end
            P_TPAD:
            begin
                if (aligned)
                begin
                    phase = P_ARGS;
                    check_args_left();
                end
            end
            P_ARGS:
            begin
                if (arg_cnt >= otmp_pkg::TUNING_ARGS)
                    phase = P_DONE;
                else
                begin
                    code = tags[arg_cnt];
                    assembly = {assembly[55:0], b};
                    asm_bytes++;
                    need = (code == otmp_pkg::TG_D) ? 8 : 4;
                    if (asm_bytes >= need)
                    begin
                        if (code == otmp_pkg::TG_I)
                            args[arg_cnt] = int_to_double(assembly[31:0]);
                        else if (code == otmp_pkg::TG_F)
                            args[arg_cnt] = single_to_double(assembly[31:0]);
                        else
                            args[arg_cnt] = assembly;
                        arg_cnt++;
                        assembly = 0;
                        asm_bytes = 0;
                        check_args_left();
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Predict the response to one accepted item.
    task automatic predict_status(input logic tick, input logic [7:0] b, input logic last);
        status_t st;
        st.msg_kind = otmp_pkg::KIND_NONE;
        st.tuning_updated = 1'b0;
        if (tick)
        begin
            if (elapsed != 32'hFFFF_FFFF) elapsed++;
        end
        else
        begin
            if (offset < otmp_pkg::MAX_PACKET_BYTES)
            begin
                walk_byte(b, offset);
                offset++;
            end
            if (last)
            begin
                if (phase == P_TAGS || phase == P_TPAD || phase == P_ARGS || phase == P_DONE)
                begin
                    st.msg_kind = addr_hit[0] ? otmp_pkg::KIND_HB : otmp_pkg::KIND_TUNE;
                    elapsed = 0;
                    seen = 1'b1;
                    if (st.msg_kind == otmp_pkg::KIND_TUNE && arg_cnt >= otmp_pkg::TUNING_ARGS)
                    begin
                        t_mode = double_to_int(args[0]);
                        t_root = args[1];
                        t_stretch = args[2];
                        t_skew = args[3];
                        t_offset = double_to_single(args[4]);
                        t_steps = double_to_count(args[5]);
                        t_mos_a = double_to_count(args[6]);
                        t_mos_b = double_to_count(args[7]);
                        st.tuning_updated = 1'b1;
                    end
                end
                clear_packet();
            end
        end
        st.connected = seen && (elapsed < {16'd0, timeout});
        st.mode = t_mode;
        st.root_bits = t_root;
        st.stretch = t_stretch;
        st.skew = t_skew;
        st.offset_bits = t_offset;
        st.steps = t_steps;
        st.mos_a = t_mos_a;
        st.mos_b = t_mos_b;
        status_q.insert(status_q.size(), st);
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        errors++;
    endtask

    // Compare one response with the oldest prediction.
    task automatic compare_status();
        status_t w;
        if (status_q.size() == 0)
        begin
            report("unexpected response", 64'd0, 64'd0);
            return;
        end
        w = status_q.pop_front();
        if (rsp.connected !== w.connected)
            report("connected", 64'(rsp.connected), 64'(w.connected));
        if (rsp.msg_kind !== w.msg_kind)
            report("msg_kind", 64'(rsp.msg_kind), 64'(w.msg_kind));
        if (rsp.tuning_updated !== w.tuning_updated)
            report("tuning_updated", 64'(rsp.tuning_updated), 64'(w.tuning_updated));
        if (rsp.mode !== w.mode) report("mode", 64'(rsp.mode), 64'(w.mode));
        if (rsp.root_bits !== w.root_bits) report("root_bits", rsp.root_bits, w.root_bits);
        if (rsp.stretch !== w.stretch) report("stretch", rsp.stretch, w.stretch);
        if (rsp.skew !== w.skew) report("skew", rsp.skew, w.skew);
        if (rsp.offset_bits !== w.offset_bits)
            report("offset_bits", 64'(rsp.offset_bits), 64'(w.offset_bits));
        if (rsp.steps !== w.steps) report("steps", 64'(rsp.steps), 64'(w.steps));
        if (rsp.mos_a !== w.mos_a) report("mos_a", 64'(rsp.mos_a), 64'(w.mos_a));
        if (rsp.mos_b !== w.mos_b) report("mos_b", 64'(rsp.mos_b), 64'(w.mos_b));
    endtask

    // Responses are checked before the new item is predicted; they never belong to it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_packet();
            for (int i = 0; i < otmp_pkg::TUNING_ARGS; i++)
            begin
                tags[i] = otmp_pkg::TG_I;
                args[i] = 64'd0;
            end
            t_mode = 0;
            t_root = 0;
            t_stretch = 0;
            t_skew = 0;
            t_offset = 0;
            t_steps = 31'd1;
            t_mos_a = 31'd1;
            t_mos_b = 31'd1;
            elapsed = 0;
            seen = 1'b0;
            timeout = otmp_pkg::TIMEOUT_RESET;
            status_q.delete();
            errors = 0;
            pending <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready) compare_status();
            if (cfg_we) timeout = cfg_wdata;
            if (req.valid && req.ready) predict_status(req.func, req.data_byte, req.last_byte);
            pending <= status_q.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
// Top of the parser testbench: clock, reset, datagram stimulus, timeout writes and verdict.
`timescale 1ns / 1ps
module testbench;

    localparam int RANDOM_ITEMS = 750;
    localparam int QUIET_TAIL   = 150;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    int          errors;
    int          pending;
    int          sent;
    int          goal;
    bit          quiet;
    bit          calm;
    int          stall_left;
    logic [7:0]  pkt[$];
    logic [7:0]  codes[$];
    logic [15:0] cur_timeout;

    otmp_req_if req_ch();
    otmp_rsp_if rsp_ch();

    osc_tuning_message_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    otmp_monitor u_monitor (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Receiver stalls come in bursts.
    always @(posedge clk)
    begin
        if (quiet || !rst_n)
            rsp_ch.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 5);
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    // Offer one item and wait until it is taken, idling first now and then.
    task automatic send_item(input logic f, input logic [7:0] b, input logic last);
        if (!quiet && !calm && $urandom_range(0, 6) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func <= f;
        req_ch.data_byte <= b;
        req_ch.last_byte <= last;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        sent++;
    endtask

    task automatic send_ticks(input int n);
        for (int i = 0; i < n; i++)
            send_item(1'b1, 8'($urandom), 1'($urandom));
    endtask

    task automatic send_packet();
        calm = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < pkt.size(); i++)
            send_item(1'b0, pkt[i], i == pkt.size() - 1);
    endtask

    // Stop offering and wait until every response has come back.
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [15:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_timeout = v;
    endtask

    // Append one byte to the packet under construction.
    task automatic put_byte(input logic [7:0] v);
        pkt.insert(pkt.size(), v);
    endtask

    task automatic pad_to_word();
        while (pkt.size() % 4 != 0)
            put_byte(($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom));
    endtask

    // Address: heartbeat, tuning, unknown name or empty.
    task automatic add_address(input int sel);
        if (sel == 0)
            for (int i = 0; i < otmp_pkg::HB_LEN; i++) put_byte(otmp_pkg::HB_NAME[i]);
        else if (sel == 1)
            for (int i = 0; i < otmp_pkg::TU_LEN; i++) put_byte(otmp_pkg::TU_NAME[i]);
        else if (sel == 2)
            repeat ($urandom_range(1, 26)) put_byte(8'($urandom_range(1, 255)));
        put_byte(8'd0);
        pad_to_word();
    endtask

    task automatic add_tags(input bit close);
        put_byte(",");
        foreach (codes[i]) put_byte(codes[i]);
        if (close)
        begin
            put_byte(8'd0);
            pad_to_word();
        end
    endtask

    task automatic pick_codes(input int n, input bit allow_bad);
        logic [7:0] c;
        codes.delete();
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, allow_bad ? 3 : 2))
                0: c = "i";
                1: c = "f";
                2: c = "d";
                default: c = 8'($urandom_range(1, 255));
            endcase
            codes.insert(codes.size(), c);
        end
    endtask

    task automatic add_word(input logic [63:0] v, input int nbytes);
        for (int i = nbytes - 1; i >= 0; i--) put_byte(v[8 * i +: 8]);
    endtask

    function automatic logic [31:0] rand_int32();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return 32'($urandom_range(0, 300)) - 32'd100;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_single();
        logic [22:0] m;
        m = ($urandom_range(0, 4) == 0) ? 23'd0 : 23'($urandom);
        case ($urandom_range(0, 4))
            0: return {1'($urandom), 8'hFF, m};
            1: return {1'($urandom), 8'h00, m};
            2: return {1'($urandom), 8'(127 + $urandom_range(0, 35)), m};
            default: return $urandom;
        endcase
    endfunction

    // Doubles aimed at the integer range, the single range edges and the specials.
    function automatic logic [63:0] rand_double();
        logic [51:0] m;
        logic [10:0] ex;
        m = {20'($urandom), $urandom};
        case ($urandom_range(0, 3))
            0: m = 52'd0;
            1: m[28:0] = 29'h1000_0000;
            default: ;
        endcase
        case ($urandom_range(0, 7))
            0: return {$urandom, $urandom};
            1: ex = 11'h7FF;
            2: ex = 11'd0;
            3: ex = 11'(1023 - $urandom_range(1, 3));
            4: ex = 11'(1023 - 126 - $urandom_range(0, 32));
            5: ex = 11'(1023 + $urandom_range(125, 129));
            default: ex = 11'(1023 + $urandom_range(0, 34));
        endcase
        return {1'($urandom_range(0, 3) == 0), ex, m};
    endfunction

    task automatic add_args();
        foreach (codes[i])
        begin
            if (codes[i] == "i") add_word({32'd0, rand_int32()}, 4);
            else if (codes[i] == "f") add_word({32'd0, rand_single()}, 4);
            else if (codes[i] == "d") add_word(rand_double(), 8);
            else add_word({32'd0, $urandom}, 4);
        end
    endtask

    task automatic build_tuning(input int nargs, input bit allow_bad);
        pkt.delete();
        add_address(1);
        pick_codes(nargs, allow_bad);
        add_tags(1'b1);
        add_args();
    endtask

    // One random packet of a random shape.
    task automatic random_packet();
        int pick;
        int cut;
        pick = $urandom_range(0, 99);
        pkt.delete();
        if (pick < 45)
            build_tuning(8, 1'b0);
        else if (pick < 55)
        begin
            add_address(0);
            pick_codes($urandom_range(0, 3), 1'b0);
            add_tags(1'b1);
            add_args();
        end
        else if (pick < 65)
            build_tuning(($urandom_range(0, 1) == 0) ? $urandom_range(0, 7)
                                                     : $urandom_range(9, 11), 1'b0);
        else if (pick < 75)
        begin
            build_tuning(8, 1'b0);
            cut = $urandom_range(1, pkt.size() - 1);
            while (pkt.size() > cut) void'(pkt.pop_back());
        end
        else if (pick < 82)
            build_tuning(8, 1'b1);
        else if (pick < 88)
        begin
            add_address($urandom_range(0, 3));
            pick_codes(3, 1'b0);
            if ($urandom_range(0, 1) == 0) put_byte(8'($urandom_range(0, 255)));
            else add_tags(1'b1);
            add_args();
        end
        else if (pick < 95)
            repeat ($urandom_range(1, 40)) put_byte(8'($urandom));
        else
        begin
            add_address($urandom_range(0, 1));
            pick_codes($urandom_range(0, 10), 1'b1);
            add_tags(1'b0);
        end
        send_packet();
    endtask

    task automatic random_gap();
        if (cur_timeout < 16 && $urandom_range(0, 2) == 0)
            send_ticks($urandom_range(0, 3 * cur_timeout));
        else
            send_ticks($urandom_range(0, 4));
    endtask

    initial
    begin
        #1_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 16'd0;
        req_ch.valid = 1'b0;
        req_ch.func = 1'b0;
        req_ch.data_byte = 8'd0;
        req_ch.last_byte = 1'b0;
        rsp_ch.ready = 1'b0;
        sent = 0;
        quiet = 1'b0;
        calm = 1'b0;
        stall_left = 0;
        cur_timeout = otmp_pkg::TIMEOUT_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: the two messages, extremes of the arguments and malformed packets.
        send_ticks(2);
        pkt.delete();
        add_address(0);
        codes.delete();
        add_tags(1'b1);
        send_packet();
        build_tuning(8, 1'b0);
        send_packet();
        pkt.delete();
        add_address(1);
        codes = '{"d", "d", "d", "d", "d", "d", "d", "d"};
        add_tags(1'b1);
        add_word({1'b0, 11'h7FF, 52'd1}, 8);
        add_word(64'hFFFF_FFFF_FFFF_FFFF, 8);
        add_word(64'd0, 8);
        add_word(64'h8000_0000_0000_0000, 8);
        add_word({1'b0, 11'h7FF, 52'h8_0000_0000_0001}, 8);
        add_word({1'b0, 11'h7FF, 52'd0}, 8);
        add_word({1'b1, 11'h7FF, 52'd0}, 8);
        add_word({1'b1, 11'd1060, 52'd0}, 8);
        send_packet();
        pkt.delete();
        add_address(1);
        codes = '{"i", "i", "f", "f", "f", "i", "i", "i", "i"};
        add_tags(1'b1);
        add_word({32'd0, 32'h8000_0000}, 4);
        add_word({32'd0, 32'h7FFF_FFFF}, 4);
        add_word({32'd0, 32'h7F80_0000}, 4);
        add_word({32'd0, 32'h0000_0001}, 4);
        add_word({32'd0, 32'hFFC0_0001}, 4);
        add_word({32'd0, 32'hFFFF_FFFF}, 4);
        add_word(64'd0, 4);
        add_word(64'd5, 4);
        add_word(64'd9, 4);
        send_packet();
        build_tuning(8, 1'b0);
        void'(pkt.pop_back());
        send_packet();
        pkt.delete();
        add_address(1);
        codes = '{"i", "x", "i"};
        add_tags(1'b1);
        add_args();
        send_packet();
        pkt = '{"/", "p"};
        send_packet();
        pkt.delete();
        add_address(1);
        send_packet();
        pkt.delete();
        add_address(0);
        put_byte("i");
        send_packet();
        pkt.delete();
        add_address(3);
        add_tags(1'b1);
        send_packet();
        pkt.delete();
        add_address(1);
        codes = '{"i", "f"};
        add_tags(1'b0);
        send_packet();

        // Timeout extremes.
        write_timeout(16'd1);
        send_ticks(2);
        build_tuning(8, 1'b0);
        send_packet();
        send_ticks(3);
        write_timeout(16'd65535);
        build_tuning(8, 1'b0);
        send_packet();
        write_timeout(16'd4);

        // Random part, with new timeouts at phase boundaries.
        goal = sent + RANDOM_ITEMS;
        while (sent < goal)
        begin
            if ($urandom_range(0, 24) == 0)
            begin
                case ($urandom_range(0, 4))
                    0: write_timeout(16'd1);
                    1: write_timeout(16'd65535);
                    2: write_timeout(16'($urandom_range(2, 12)));
                    default: write_timeout(16'($urandom_range(1, 65535)));
                endcase
            end
            if (sent > goal - QUIET_TAIL) quiet = 1'b1;
            random_packet();
            random_gap();
        end

        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
